/* sv/servo_mask_chunk_scheduler_assert.svh */
// Assertion macros shared by the servo mask chunk scheduler RTL.
`ifndef SERVO_MASK_CHUNK_SCHEDULER_ASSERT_SVH
`define SERVO_MASK_CHUNK_SCHEDULER_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define SMCS_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define SMCS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* sv/smcs_pkg.sv */
// Types, constants and codes shared by the servo mask chunk scheduler modules.
package smcs_pkg;

  localparam int unsigned MotorCountDef = 16;
  localparam int unsigned MaskW         = 16;
  localparam int unsigned StepW         = 16;
  localparam int unsigned SelW          = 4;
  localparam int unsigned LimitW        = 5;
  localparam int unsigned CfgIdxW       = 1;
  localparam int unsigned CfgDataW      = 16;
  localparam int unsigned QueueDepth    = 2;

  localparam logic [MaskW-1:0]  HipMaskRst   = 16'h9249;
  localparam logic [LimitW-1:0] MaxActiveRst = 5'd4;
  localparam logic [LimitW-1:0] LimitMin     = 5'd1;
  localparam logic [LimitW-1:0] LimitMax     = 5'd16;

  typedef enum logic {
    ACT_MOVE = 1'b0,
    ACT_READ = 1'b1
  } smcs_action_e;

  typedef enum logic [CfgIdxW-1:0] {
    REG_HIP_MASK   = 1'b0,
    REG_MAX_ACTIVE = 1'b1
  } smcs_reg_e;

  typedef enum logic {
    BK_IDLE,
    BK_RUN
  } smcs_back_e;

  typedef struct packed {
    smcs_action_e             action;
    logic [MaskW-1:0]         move_bits;
    logic signed [StepW-1:0]  angle_step;
    logic [SelW-1:0]          motor_select;
  } smcs_in_t;

  typedef struct packed {
    logic [MaskW-1:0]         chunk_mask;
    logic                     hip_phase;
    logic                     last_chunk;
    logic signed [StepW-1:0]  position_value;
  } smcs_out_t;

  // A classified command as it waits between the front and the back.
  typedef struct packed {
    smcs_action_e             action;
    logic [MaskW-1:0]         hip_bits;
    logic [MaskW-1:0]         rest_mask;
    logic signed [StepW-1:0]  step;
    logic [SelW-1:0]          sel;
    logic                     sel_ok;
    logic [LimitW-1:0]        limit;
  } smcs_cmd_t;

  typedef struct packed {
    logic empty;
    logic full;
  } smcs_qstat_t;

endpackage

/* sv/servo_mask_chunk_scheduler.sv */
// Top level of the servo mask chunk scheduler: config registers, front end, queue, back end.
//
//   Channel  Dir  Handshake                 Beat content
//   in       in   in_valid_i / in_ready_o   smcs_in_t: action, mask, step, motor select
//   out      out  out_valid_o / out_ready_i smcs_out_t: chunk mask, phase, last, position
//   cfg      in   cfg_valid_i / cfg_ready_o cfg_index_i register index, cfg_data_i value
//
// A move command is loaded from the queue while the back end is idle, then its chunks are
// emitted one by one while it runs, at most 16 chunks when the limit is one motor each.
// A read or an empty move gives one beat. The chunk sequencer in the back end sets this.
// The queue holds two classified commands, so up to two beats are taken ahead of the
// back end; a stalled output beat holds the back end, and a full queue holds the input.
// Reset clears all motor positions and loads the config defaults at once; no clearing pass.
`include "servo_mask_chunk_scheduler_assert.svh"

module servo_mask_chunk_scheduler #(
  parameter int unsigned MOTOR_COUNT = smcs_pkg::MotorCountDef
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  smcs_pkg::smcs_in_t                in_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output smcs_pkg::smcs_out_t               out_o,
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [smcs_pkg::CfgIdxW-1:0]      cfg_index_i,
  input  logic [smcs_pkg::CfgDataW-1:0]     cfg_data_i
);
  import smcs_pkg::*;

  logic [MaskW-1:0]  hip_bits_q, hip_bits_d;
  logic [LimitW-1:0] max_active_q, max_active_d;

  smcs_qstat_t qstat;
  smcs_cmd_t   push_cmd, head_cmd;
  logic        push, pop;

  logic        in_fire, out_fire, rest_fire, hip_shown;

  assign cfg_ready_o = 1'b1;

  always_comb begin
    hip_bits_d   = hip_bits_q;
    max_active_d = max_active_q;
    if (cfg_valid_i) begin
      case (smcs_reg_e'(cfg_index_i))
        REG_HIP_MASK:   hip_bits_d   = cfg_data_i[MaskW-1:0];
        REG_MAX_ACTIVE: max_active_d = cfg_data_i[LimitW-1:0];
        default: begin
          hip_bits_d   = hip_bits_q;
          max_active_d = max_active_q;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hip_bits_q   <= HipMaskRst;
      max_active_q <= MaxActiveRst;
    end else begin
      hip_bits_q   <= hip_bits_d;
      max_active_q <= max_active_d;
    end
  end

  smcs_front #(
    .MOTOR_COUNT (MOTOR_COUNT)
  ) u_front (
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .in_i         (in_i),
    .hip_bits_i   (hip_bits_q),
    .max_active_i (max_active_q),
    .qstat_i      (qstat),
    .push_o       (push),
    .cmd_o        (push_cmd)
  );

  smcs_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .cmd_i   (push_cmd),
    .pop_i   (pop),
    .cmd_o   (head_cmd),
    .qstat_o (qstat)
  );

  smcs_back #(
    .MOTOR_COUNT (MOTOR_COUNT)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .qstat_i     (qstat),
    .cmd_i       (head_cmd),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_o       (out_o)
  );

  assign in_fire   = in_valid_i && in_ready_o;
  assign out_fire  = out_valid_o && out_ready_i;
  assign rest_fire = out_fire && !out_o.hip_phase && !out_o.last_chunk;
  assign hip_shown = out_valid_o && out_o.hip_phase;

  // The back end only loads a command that the queue actually holds.
  `SMCS_ASSERT_IMPL(a_pop_has_entry, clk_i, rst_ni, pop, !qstat.empty, "pop from empty queue")

  // An accepted input beat is in the queue at the next edge.
  `SMCS_ASSERT_NEXT(a_accept_queued, clk_i, rst_ni, in_fire, !qstat.empty, "beat not queued")

  // Once the non-hip pass of a command has started, no hip chunk follows it.
  `SMCS_ASSERT_NEXT(a_hip_first, clk_i, rst_ni, rest_fire, !hip_shown, "late hip chunk")

endmodule

/* sv/smcs_front.sv */
// Front end: accepts input beats and splits each move into hip and remaining masks.
module smcs_front #(
  parameter int unsigned MOTOR_COUNT = smcs_pkg::MotorCountDef
) (
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  smcs_pkg::smcs_in_t                in_i,
  input  logic [smcs_pkg::MaskW-1:0]        hip_bits_i,
  input  logic [smcs_pkg::LimitW-1:0]       max_active_i,
  input  smcs_pkg::smcs_qstat_t             qstat_i,
  output logic                              push_o,
  output smcs_pkg::smcs_cmd_t               cmd_o
);
  import smcs_pkg::*;

  logic [MaskW-1:0]  usable;
  logic [MaskW-1:0]  mask;
  logic [LimitW-1:0] limit;

  // Mask bits at or above the motor count never reach a motor.
  always_comb begin
    for (int i = 0; i < MaskW; i++) begin
      usable[i] = (i < MOTOR_COUNT);
    end
  end

  always_comb begin
    if (max_active_i == '0) begin
      limit = LimitMin;
    end else if (max_active_i > LimitMax) begin
      limit = LimitMax;
    end else begin
      limit = max_active_i;
    end
  end

  assign mask = in_i.move_bits & usable;

  always_comb begin
    cmd_o.action    = in_i.action;
    cmd_o.hip_bits  = mask & hip_bits_i;
    cmd_o.rest_mask = mask & ~hip_bits_i;
    cmd_o.step      = in_i.angle_step;
    cmd_o.sel       = in_i.motor_select;
    cmd_o.sel_ok    = (32'(in_i.motor_select) < MOTOR_COUNT);
    cmd_o.limit     = limit;
  end

  assign in_ready_o = !qstat_i.full;
  assign push_o     = in_valid_i && !qstat_i.full;

endmodule

/* sv/smcs_queue.sv */
// Short command queue between the front end and the chunk sequencer.
module smcs_queue (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  push_i,
  input  smcs_pkg::smcs_cmd_t   cmd_i,
  input  logic                  pop_i,
  output smcs_pkg::smcs_cmd_t   cmd_o,
  output smcs_pkg::smcs_qstat_t qstat_o
);
  import smcs_pkg::*;

  localparam int unsigned PtrW = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
  localparam int unsigned CntW = $clog2(QueueDepth + 1);

  smcs_cmd_t       entry_q [QueueDepth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            do_push, do_pop;

  assign qstat_o.empty = (cnt_q == '0);
  assign qstat_o.full  = (cnt_q == CntW'(QueueDepth));
  assign do_push       = push_i && !qstat_o.full;
  assign do_pop        = pop_i && !qstat_o.empty;
  assign cmd_o         = entry_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(QueueDepth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(QueueDepth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      entry_q[wr_ptr_q] <= cmd_i;
    end
  end

endmodule

/* sv/smcs_back.sv */
// Back end: walks each command chunk by chunk, updates positions and drives result beats.
module smcs_back #(
  parameter int unsigned MOTOR_COUNT = smcs_pkg::MotorCountDef
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  smcs_pkg::smcs_qstat_t qstat_i,
  input  smcs_pkg::smcs_cmd_t   cmd_i,
  output logic                  pop_o,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output smcs_pkg::smcs_out_t   out_o
);
  import smcs_pkg::*;

  localparam int unsigned NumPos  = (MOTOR_COUNT < MaskW) ? MOTOR_COUNT : MaskW;
  localparam int unsigned PosIdxW = (NumPos > 1) ? $clog2(NumPos) : 1;

  smcs_back_e              state_q, state_d;
  smcs_cmd_t               cur_q, cur_d;
  logic signed [StepW-1:0] pos_q [NumPos];
  logic signed [StepW-1:0] pos_d [NumPos];
  logic                    out_valid_q, out_valid_d;
  smcs_out_t               out_q, out_d;

  logic                    can_emit, emit, last;
  logic                    in_hip;
  logic [MaskW-1:0]        src, chunk, hip_left, rest_left;
  logic signed [StepW-1:0] read_pos;

  // Keep the lowest set bits of m, at most lim of them.
  function automatic logic [MaskW-1:0] take_low(input logic [MaskW-1:0] m,
                                                input logic [LimitW-1:0] lim);
    logic [MaskW-1:0] r;
    logic [MaskW-1:0] upto;
    r = '0;
    for (int i = 0; i < MaskW; i++) begin
      upto = m & ~({MaskW{1'b1}} << (i + 1));
      r[i] = m[i] && ($countones(upto) <= int'(lim));
    end
    return r;
  endfunction

  function automatic logic signed [StepW-1:0] sat_add(input logic signed [StepW-1:0] a,
                                                     input logic signed [StepW-1:0] b);
    logic signed [StepW:0] s;
    s = $signed({a[StepW-1], a}) + $signed({b[StepW-1], b});
    if (s[StepW] != s[StepW-1]) begin
      return s[StepW] ? {1'b1, {(StepW-1){1'b0}}} : {1'b0, {(StepW-1){1'b1}}};
    end
    return s[StepW-1:0];
  endfunction

  assign can_emit = !out_valid_q || out_ready_i;

  // Hip motors drain completely before the remaining motors start.
  assign in_hip    = (cur_q.hip_bits != '0);
  assign src       = in_hip ? cur_q.hip_bits : cur_q.rest_mask;
  assign chunk     = (cur_q.action == ACT_MOVE) ? take_low(src, cur_q.limit) : '0;
  assign hip_left  = in_hip ? (cur_q.hip_bits & ~chunk) : cur_q.hip_bits;
  assign rest_left = in_hip ? cur_q.rest_mask : (cur_q.rest_mask & ~chunk);
  assign last      = (cur_q.action == ACT_READ) || ((hip_left == '0) && (rest_left == '0));
  assign read_pos  = cur_q.sel_ok ? pos_q[cur_q.sel[PosIdxW-1:0]] : '0;

  always_comb begin
    state_d = state_q;
    case (state_q)
      BK_IDLE: begin
        if (!qstat_i.empty) begin
          state_d = BK_RUN;
        end
      end
      BK_RUN: begin
        if (can_emit && last) begin
          state_d = BK_IDLE;
        end
      end
      default: state_d = BK_IDLE;
    endcase
  end

  always_comb begin
    pop_o = 1'b0;
    emit  = 1'b0;
    case (state_q)
      BK_IDLE: pop_o = !qstat_i.empty;
      BK_RUN:  emit  = can_emit;
      default: begin
        pop_o = 1'b0;
        emit  = 1'b0;
      end
    endcase
  end

  always_comb begin
    cur_d = cur_q;
    if (pop_o) begin
      cur_d = cmd_i;
    end else if (emit) begin
      cur_d.hip_bits  = hip_left;
      cur_d.rest_mask = rest_left;
    end
  end

  always_comb begin
    for (int i = 0; i < NumPos; i++) begin
      pos_d[i] = pos_q[i];
      if (emit && chunk[i]) begin
        pos_d[i] = sat_add(pos_q[i], cur_q.step);
      end
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    out_d       = out_q;
    if (emit) begin
      out_valid_d          = 1'b1;
      out_d.chunk_mask     = chunk;
      out_d.hip_phase      = (cur_q.action == ACT_MOVE) && in_hip;
      out_d.last_chunk     = last;
      out_d.position_value = (cur_q.action == ACT_READ) ? read_pos : '0;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= BK_IDLE;
      out_valid_q <= 1'b0;
      for (int i = 0; i < NumPos; i++) begin
        pos_q[i] <= '0;
      end
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      for (int i = 0; i < NumPos; i++) begin
        pos_q[i] <= pos_d[i];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    cur_q <= cur_d;
    out_q <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

endmodule
